>>> rtl/psv_pkg.sv
package psv_pkg;

  localparam int SEG_SIZE_DEF  = 4096;
  localparam int NUM_WIDTH_DEF = 40;

  localparam int TYPE_W    = 2;
  localparam int PRIME_W   = 20;
  localparam int IDX_W     = 6;
  localparam int WORD_W    = 64;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 1;
  localparam int LEN_CFG_W = 13;

  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 13'd4096;

  localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_STRIKE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_STRIKE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic               valid;
    cmd_kind_t          kind;
    logic [PRIME_W-1:0] prime;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> rtl/psv_in_if.sv
interface psv_in_if;
  logic                              valid;
  logic                              ready;
  logic [psv_pkg::TYPE_W-1:0]        req_type;
  logic [psv_pkg::PRIME_W-1:0]       base_prime;
  logic [psv_pkg::IDX_W-1:0]         word_index;

  modport source (output valid, req_type, base_prime, word_index, input ready);
  modport sink   (input valid, req_type, base_prime, word_index, output ready);
endinterface

>>> rtl/psv_out_if.sv
interface psv_out_if;
  logic                        valid;
  logic                        ready;
  logic [psv_pkg::WORD_W-1:0]  flag_word;
  logic [psv_pkg::IDX_W-1:0]   word_number;

  modport source (output valid, flag_word, word_number, input ready);
  modport sink   (input valid, flag_word, word_number, output ready);
endinterface

>>> rtl/psv_ram.sv
module psv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [psv_pkg::addr_w(DEPTH)-1:0]      waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [psv_pkg::addr_w(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/psv_div.sv
// Remainder of start by prime, restoring, one dividend bit per cycle.
module psv_div #(
  parameter int NUM_WIDTH = psv_pkg::NUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [NUM_WIDTH-1:0]          dividend,
  input  logic [psv_pkg::PRIME_W-1:0]   divisor,
  output logic                          done,
  output logic [psv_pkg::PRIME_W-1:0]   rem
);

  localparam int CNT_W = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0]          shift_r;
  logic [psv_pkg::PRIME_W-1:0]   rem_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          done_r;
  logic [psv_pkg::PRIME_W:0]     trial;

  assign trial = {rem_r, shift_r[NUM_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(NUM_WIDTH);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_r <= dividend;
      rem_r   <= '0;
    end else if (cnt_r != '0) begin
      shift_r <= shift_r << 1;
      if (trial >= {1'b0, divisor}) begin
        rem_r <= psv_pkg::PRIME_W'(trial - {1'b0, divisor});
      end else begin
        rem_r <= psv_pkg::PRIME_W'(trial);
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/psv_front.sv
// Accepts requests, drops the ones with no effect, queues the rest.
module psv_front #(
  parameter int SEG_SIZE = psv_pkg::SEG_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  psv_in_if.sink               in_ch,
  input  psv_pkg::back_stat_t  stat,
  output psv_pkg::cmd_t        q_head
);

  localparam int Words = (SEG_SIZE + 63) / 64;

  psv_pkg::cmd_t  q_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           accept;
  logic           keep;
  psv_pkg::cmd_t  item;

  assign in_ch.ready = (count_r != 2'd2) && !stat.init_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    item          = '0;
    item.valid    = 1'b1;
    item.prime    = in_ch.base_prime;
    item.idx      = in_ch.word_index;
    item.in_range = (int'(in_ch.word_index) < Words);
    keep          = 1'b0;
    unique case (in_ch.req_type)
      psv_pkg::REQ_CLEAR: begin
        item.kind = psv_pkg::CMD_CLEAR;
        keep      = 1'b1;
      end
      psv_pkg::REQ_STRIKE: begin
        item.kind = psv_pkg::CMD_STRIKE;
        keep      = (in_ch.base_prime != '0);
      end
      psv_pkg::REQ_READ: begin
        item.kind = psv_pkg::CMD_READ;
        keep      = 1'b1;
      end
      default: begin
        item.kind = psv_pkg::CMD_CLEAR;
        keep      = 1'b0;
      end
    endcase
  end

  logic push;
  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (stat.pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !stat.pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && stat.pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_comb begin
    q_head       = q_r[rd_ptr_r];
    q_head.valid = (count_r != 2'd0);
  end

endmodule

>>> rtl/psv_back.sv
// Executes queued requests against the flag store.
module psv_back #(
  parameter int SEG_SIZE  = psv_pkg::SEG_SIZE_DEF,
  parameter int NUM_WIDTH = psv_pkg::NUM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psv_pkg::cmd_t                     q_head,
  output psv_pkg::back_stat_t               stat,
  input  logic [NUM_WIDTH-1:0]              seg_start,
  input  logic [$clog2(SEG_SIZE+1)-1:0]     seg_len,
  psv_out_if.source                         out_ch
);

  localparam int LEN_W  = $clog2(SEG_SIZE + 1);
  localparam int Words  = (SEG_SIZE + 63) / 64;
  localparam int AW     = psv_pkg::addr_w(Words);
  localparam int PW     = psv_pkg::PRIME_W;
  localparam int OFF_W  = ((LEN_W > PW + 1) ? LEN_W : PW + 1) + 1;
  localparam int CW     = (NUM_WIDTH > PW + 1) ? NUM_WIDTH : PW + 1;
  localparam int WW     = psv_pkg::WORD_W;

  typedef enum logic [8:0] {
    ST_INIT     = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_CLEAR    = 9'b000000100,
    ST_DIV      = 9'b000001000,
    ST_FETCH    = 9'b000010000,
    ST_LOAD     = 9'b000100000,
    ST_MARK     = 9'b001000000,
    ST_RD_ISSUE = 9'b010000000,
    ST_RD_DATA  = 9'b100000000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [AW-1:0]          sweep_r;
  logic [PW-1:0]          prime_r;
  logic [psv_pkg::IDX_W-1:0] idx_r;
  logic                   in_range_r;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [WW-1:0]          word_r, word_nxt;
  logic                   out_valid_r;
  logic [WW-1:0]          out_word_r;
  logic [psv_pkg::IDX_W-1:0] out_num_r;
  logic                   div_go_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WW-1:0]          ram_wdata, ram_rdata;

  logic                   div_start, div_done;
  logic [PW-1:0]          div_rem;

  logic [OFF_W-1:0]       len_ext, step_off, first_off;
  logic [WW-1:0]          cleared, mask0;
  logic                   sweep_last, pop;
  logic [PW:0]            two_p;

  psv_ram #(.WIDTH(WW), .DEPTH(Words)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psv_div #(.NUM_WIDTH(NUM_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (seg_start),
    .divisor  (prime_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign len_ext    = OFF_W'(seg_len);
  assign step_off   = off_r + OFF_W'(prime_r);
  assign cleared    = word_r & ~(WW'(1) << off_r[5:0]);
  assign sweep_last = (sweep_r == AW'(Words - 1));
  assign two_p      = {prime_r, 1'b0};

  // 0 and 1 lose their flags on a clear when they lie in the segment
  always_comb begin
    mask0 = '1;
    if (seg_start == '0) begin
      if (seg_len >= LEN_W'(1)) mask0[0] = 1'b0;
      if (seg_len >= LEN_W'(2)) mask0[1] = 1'b0;
    end else if (seg_start == NUM_WIDTH'(1)) begin
      if (seg_len >= LEN_W'(1)) mask0[0] = 1'b0;
    end
  end

  // strike starts at max(first multiple at or past start, 2p)
  always_comb begin
    if (CW'(two_p) > CW'(seg_start)) begin
      first_off = OFF_W'(CW'(two_p) - CW'(seg_start));
    end else if (div_rem == '0) begin
      first_off = '0;
    end else begin
      first_off = OFF_W'(prime_r - div_rem);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    off_nxt   = off_r;
    word_nxt  = word_r;
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = '1;
    ram_raddr = AW'(off_r >> 6);
    div_start = div_go_r;
    pop       = 1'b0;
    unique case (st_r)
      ST_INIT: begin
        ram_we = 1'b1;
        if (sweep_last) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_head.valid) begin
          pop = 1'b1;
          unique case (q_head.kind)
            psv_pkg::CMD_CLEAR:  st_nxt = ST_CLEAR;
            psv_pkg::CMD_STRIKE: begin
              if (seg_len != '0) st_nxt = ST_DIV;
            end
            psv_pkg::CMD_READ:   st_nxt = ST_RD_ISSUE;
            default:             st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (sweep_r == '0) ? mask0 : '1;
        if (sweep_last) st_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          off_nxt = first_off;
          st_nxt  = ST_FETCH;
        end
      end
      ST_FETCH: begin
        st_nxt = (off_r >= len_ext) ? ST_IDLE : ST_LOAD;
      end
      ST_LOAD: begin
        word_nxt = ram_rdata;
        st_nxt   = ST_MARK;
      end
      ST_MARK: begin
        off_nxt  = step_off;
        word_nxt = cleared;
        if (step_off >= len_ext ||
            step_off[OFF_W-1:6] != off_r[OFF_W-1:6]) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(off_r >> 6);
          ram_wdata = cleared;
          ram_raddr = AW'(step_off >> 6);
          st_nxt    = (step_off >= len_ext) ? ST_IDLE : ST_LOAD;
        end
      end
      ST_RD_ISSUE: begin
        ram_raddr = AW'(idx_r);
        if (!out_valid_r || out_ch.ready) st_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ram_we && (st_r == ST_INIT || st_r == ST_CLEAR)) begin
        sweep_r <= sweep_last ? '0 : sweep_r + AW'(1);
      end
      if (st_r == ST_RD_DATA) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    word_r <= word_nxt;
    if (pop) begin
      prime_r    <= q_head.prime;
      idx_r      <= q_head.idx;
      in_range_r <= q_head.in_range;
    end
    if (st_r == ST_RD_DATA) begin
      out_word_r <= in_range_r ? ram_rdata : '0;
      out_num_r  <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= (st_r == ST_IDLE) && (st_nxt == ST_DIV);
    end
  end

  assign stat.pop       = pop;
  assign stat.init_busy = (st_r == ST_INIT);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.flag_word   = out_word_r;
  assign out_ch.word_number = out_num_r;

  // divider kicks off the cycle after the strike is popped, prime_r is loaded by then
  psv_div_kick : assert property (@(posedge clk) disable iff (!rst_n)
    $past(pop) && st_r == ST_DIV |-> div_go_r)
    else $error("divider not started for strike");

  a_onehot : assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");

  a_mark_in_seg : assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MARK |-> off_r < len_ext)
    else $error("strike offset past segment end");

  a_out_free : assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RD_DATA |-> (!out_valid_r || $past(out_ch.ready)))
    else $error("read data with output register busy");

  a_no_accept_init : assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_INIT |-> !pop)
    else $error("queue popped during init sweep");

endmodule

>>> rtl/segmented_prime_sieve_core.sv
// Channel  Dir  Payload                                  Handshake
// in_ch    in   req_type[2] base_prime[20] word_index[6] valid/ready
// out_ch   out  flag_word[64] word_number[6]              valid/ready
// cfg_*    in   cfg_index[1] cfg_wdata[40]                cfg_we, no wait
//
// Clear: one store word written per cycle.
// Strike: the serial remainder first, then the multiples are marked one by one,
//   with a load of each store word touched.
// Read: through the registered RAM port into the output register.
// After reset the store is swept to ones; in_ch.ready
//   stays low during that sweep. A two-entry request queue sits in front.
module segmented_prime_sieve_core #(
  parameter int SEG_SIZE  = psv_pkg::SEG_SIZE_DEF,
  parameter int NUM_WIDTH = psv_pkg::NUM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  psv_in_if.sink                            in_ch,
  psv_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [psv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psv_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int LEN_W = $clog2(SEG_SIZE + 1);
  localparam int CMP_W = (LEN_W > psv_pkg::LEN_CFG_W) ? LEN_W : psv_pkg::LEN_CFG_W;

  logic [NUM_WIDTH-1:0]           start_r;
  logic [psv_pkg::LEN_CFG_W-1:0]  len_r;
  logic [LEN_W-1:0]               len_eff;
  psv_pkg::cmd_t                  q_head;
  psv_pkg::back_stat_t            stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= psv_pkg::LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psv_pkg::CFG_START:  start_r <= NUM_WIDTH'(cfg_wdata);
        psv_pkg::CFG_LENGTH: len_r   <= cfg_wdata[psv_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (CMP_W'(len_r) > CMP_W'(SEG_SIZE)) ? LEN_W'(SEG_SIZE) : LEN_W'(len_r);

  psv_front #(.SEG_SIZE(SEG_SIZE)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .stat   (stat),
    .q_head (q_head)
  );

  psv_back #(.SEG_SIZE(SEG_SIZE), .NUM_WIDTH(NUM_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .stat      (stat),
    .seg_start (start_r),
    .seg_len   (len_eff),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import psv_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STORE_WORDS = 64;
  localparam int SEG_CAP = 4096;
  localparam int DRAIN_CYCLES = 8000;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int RX_LONG_HOLD = 3000;

  typedef struct {
    logic [TYPE_W-1:0]  kind;
    logic [PRIME_W-1:0] prime;
    logic [IDX_W-1:0]   idx;
  } sieve_req_t;

  typedef struct {
    logic [WORD_W-1:0] flags;
    logic [IDX_W-1:0]  num;
  } flag_read_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  logic [CFG_W-1:0] cfg_wdata = '0;

  psv_in_if  req_if();
  psv_out_if word_if();

  segmented_prime_sieve_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(req_if), .out_ch(word_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the sieve state
  logic [WORD_W-1:0] shadow_flags [STORE_WORDS];
  longint unsigned seg_start;
  longint unsigned seg_len;

  sieve_req_t pending_q[$];
  flag_read_t read_exp_q[$];
  int errors = 0;
  int reads_seen = 0;
  int reqs_taken = 0;
  int cycles = 0;
  bit no_idle = 0;
  bit sender_hold = 0;
  int stall_trigger = 0;

  function automatic longint unsigned eff_len();
    return (seg_len > SEG_CAP) ? SEG_CAP : seg_len;
  endfunction

  function automatic void sieve_clear();
    longint unsigned len;
    len = eff_len();
    foreach (shadow_flags[w]) shadow_flags[w] = '1;
    for (longint unsigned n = 0; n < 2; n++)
      if (n >= seg_start && n - seg_start < len)
        shadow_flags[(n - seg_start) >> 6][(n - seg_start) & 63] = 1'b0;
  endfunction

  function automatic void sieve_strike(logic [PRIME_W-1:0] prime);
    longint unsigned len, p, last, first, off;
    len = eff_len();
    p = prime;
    if (p == 0 || len == 0) return;
    last = seg_start + len - 1;
    first = (seg_start / p) * p;
    if (first < seg_start) first += p;
    if (first < 2 * p) first = 2 * p;
    for (longint unsigned j = first; j <= last; j += p) begin
      off = j - seg_start;
      if (off < SEG_CAP) shadow_flags[off >> 6][off & 63] = 1'b0;
    end
  endfunction

  function automatic void sieve_apply(sieve_req_t r);
    flag_read_t e;
    case (r.kind)
      REQ_CLEAR: sieve_clear();
      REQ_STRIKE: sieve_strike(r.prime);
      REQ_READ: begin
        e.flags = (r.idx < STORE_WORDS) ? shadow_flags[r.idx] : '0;
        e.num = r.idx;
        read_exp_q.insert(read_exp_q.size(), e);
      end
      default: ;
    endcase
  endfunction

  // request side: acceptance seen at posedge, driving at negedge
  bit req_fire = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    req_fire = req_if.valid && req_if.ready;
    if (req_fire) begin
      sieve_req_t r;
      r.kind = req_if.req_type;
      r.prime = req_if.base_prime;
      r.idx = req_if.word_index;
      sieve_apply(r);
      reqs_taken++;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (req_if.valid && !req_fire) begin
      // hold the request until taken
    end else if (gap_left > 0) begin
      req_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() > 0 && !sender_hold && rst_n) begin
      sieve_req_t r;
      r = pending_q.pop_front();
      req_if.valid <= 1'b1;
      req_if.req_type <= r.kind;
      req_if.base_prime <= r.prime;
      req_if.word_index <= r.idx;
      gap_left <= pick_gap();
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // result side
  int hold_left = 0;
  int stall_seen = 0;

  always @(negedge clk) begin
    if (stall_trigger != stall_seen) begin
      stall_seen <= stall_trigger;
      hold_left <= RX_LONG_HOLD;
      word_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      word_if.ready <= 1'b0;
    end else if (no_idle) begin
      word_if.ready <= 1'b1;
    end else begin
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) word_if.ready <= 1'b1;
      else if (roll < 96) word_if.ready <= 1'b0;
      else begin
        word_if.ready <= 1'b0;
        hold_left <= $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (word_if.valid && word_if.ready) begin
      reads_seen++;
      if (read_exp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected read word: flags=%h num=%0d",
                   word_if.flag_word, word_if.word_number);
      end else begin
        flag_read_t e;
        e = read_exp_q.pop_front();
        if (word_if.flag_word !== e.flags || word_if.word_number !== e.num) begin
          errors++;
          if (errors <= 10)
            $display("read mismatch: exp flags=%h num=%0d got flags=%h num=%0d",
                     e.flags, e.num, word_if.flag_word, word_if.word_number);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    if (idx == CFG_START) seg_start = val & ((64'd1 << CFG_W) - 1);
    else seg_len = val & 64'h1FFF;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_req(logic [TYPE_W-1:0] kind, logic [PRIME_W-1:0] prime,
                          logic [IDX_W-1:0] idx);
    sieve_req_t r;
    r.kind = kind;
    r.prime = prime;
    r.idx = idx;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || req_if.valid || read_exp_q.size() > 0)
      @(posedge clk);
    // strikes leave no result, so give the back end time to finish
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PRIME_W-1:0] pick_prime();
    int roll;
    int small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    roll = $urandom_range(0, 99);
    if (roll < 55) return small_primes[$urandom_range(0, 11)];
    if (roll < 75) return $urandom_range(41, 4000);
    if (roll < 92) return $urandom_range(0, (1 << PRIME_W) - 1);
    if (roll < 96) return 1;
    return 0;
  endfunction

  task automatic random_phase(int n_items);
    int roll;
    int words;
    longint unsigned start;
    roll = $urandom_range(0, 99);
    if (roll < 30) start = $urandom_range(0, 3);
    else if (roll < 60) start = $urandom_range(0, 100000);
    else if (roll < 85) start = {$urandom(), $urandom()} & ((64'd1 << CFG_W) - 1);
    else start = (64'd1 << CFG_W) - 1 - $urandom_range(0, 5000);
    write_reg(CFG_START, start);
    roll = $urandom_range(0, 99);
    if (roll < 20) write_reg(CFG_LENGTH, SEG_CAP);
    else if (roll < 25) write_reg(CFG_LENGTH, 13'h1FFF);
    else if (roll < 28) write_reg(CFG_LENGTH, 0);
    else write_reg(CFG_LENGTH, $urandom_range(1, 700));
    words = (eff_len() + 63) / 64;
    if (words == 0) words = 1;
    push_req(REQ_CLEAR, $urandom(), $urandom());
    for (int i = 1; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) push_req(REQ_STRIKE, pick_prime(), $urandom());
      else if (roll < 85) push_req(REQ_READ, $urandom(), $urandom_range(0, words - 1));
      else if (roll < 92) push_req(REQ_READ, $urandom(), $urandom());
      else if (roll < 96) push_req(REQ_CLEAR, $urandom(), $urandom());
      else push_req(REQ_UNUSED, $urandom(), $urandom());
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = REQ_CLEAR;
    req_if.base_prime = '0;
    req_if.word_index = '0;
    word_if.ready = 1'b0;
    foreach (shadow_flags[w]) shadow_flags[w] = '1;
    seg_start = 0;
    seg_len = LEN_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);

    // directed: default segment from zero, then edges
    push_req(REQ_READ, 0, 0);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_STRIKE, 2, 0);
    push_req(REQ_STRIKE, 3, 0);
    push_req(REQ_STRIKE, 0, 0);
    push_req(REQ_STRIKE, 20'hFFFFF, 0);
    push_req(REQ_STRIKE, 2039, 0);
    push_req(REQ_UNUSED, 20'hFFFFF, 6'h3F);
    push_req(REQ_READ, 20'hFFFFF, 0);
    push_req(REQ_READ, 0, 1);
    push_req(REQ_READ, 0, 63);
    wait_idle();

    write_reg(CFG_START, (64'd1 << CFG_W) - 1);
    write_reg(CFG_LENGTH, 1);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_STRIKE, 1, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_READ, 0, 1);
    wait_idle();

    write_reg(CFG_START, 1);
    write_reg(CFG_LENGTH, 0);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_STRIKE, 2, 0);
    push_req(REQ_READ, 0, 0);
    wait_idle();

    write_reg(CFG_LENGTH, 200);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_STRIKE, 1, 0);
    push_req(REQ_READ, 0, 0);
    push_req(REQ_READ, 0, 3);
    push_req(REQ_READ, 0, 4);
    wait_idle();

    // long receiver stall while reads keep coming in
    write_reg(CFG_START, 0);
    write_reg(CFG_LENGTH, 13'h1FFF);
    push_req(REQ_CLEAR, 0, 0);
    push_req(REQ_STRIKE, 5, 0);
    wait_idle();
    stall_trigger++;
    for (int i = 0; i < 20; i++) push_req(REQ_READ, 0, $urandom());
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 2);
      random_phase(30);
      if (ph == 4) begin
        // sender stops until all reads are back, then carries on
        while (pending_q.size() > 15) @(posedge clk);
        sender_hold = 1;
        while (req_if.valid || read_exp_q.size() > 0) @(posedge clk);
        sender_hold = 0;
      end
      wait_idle();
    end
    no_idle = 0;

    if (read_exp_q.size() > 0) begin
      errors++;
      $display("%0d reads never returned", read_exp_q.size());
    end
    $display("covered %0d requests and %0d read words over %0d cycles",
             reqs_taken, reads_seen, cycles);
    $display("clear, strike, read, unused selector, empty and saturated segments");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
